/* sv/ptc_pkg.sv */
// Shared constants and arithmetic helpers for the pressure/temperature
// compensation pipeline. No dependencies.
package ptc_pkg;

  // Pipeline depth, input register to output register
  localparam int NSTG = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_SENSOR_MODEL   = 3'd0;
  localparam logic [2:0] REG_PRESS_SENS     = 3'd1;
  localparam logic [2:0] REG_PRESS_OFFSET   = 3'd2;
  localparam logic [2:0] REG_SENS_TEMP_COEF = 3'd3;
  localparam logic [2:0] REG_OFF_TEMP_COEF  = 3'd4;
  localparam logic [2:0] REG_REF_TEMP       = 3'd5;
  localparam logic [2:0] REG_TEMP_COEF      = 3'd6;

  // Temperature base (20.00 C) and the very-low threshold (-15.00 C)
  // expressed as an offset from the base.
  localparam logic signed [19:0] TEMP_BASE    = 20'sd2000;
  localparam logic signed [18:0] VLOW_OFFSET  = 19'sd3500;

  // Power-of-two divisors, by model
  localparam logic [5:0] SH_TEMP      = 6'd23;
  localparam logic [5:0] SH_PROD      = 6'd21;
  localparam logic [5:0] SH_SENS_2BAR = 6'd7;
  localparam logic [5:0] SH_SENS_30B  = 6'd8;
  localparam logic [5:0] SH_OFF_2BAR  = 6'd6;
  localparam logic [5:0] SH_OFF_30B   = 6'd7;
  localparam logic [5:0] SH_P_2BAR    = 6'd15;
  localparam logic [5:0] SH_P_30B     = 6'd13;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input logic [5:0] k);
    logic signed [63:0] bias;
    bias = x[63] ? $signed((64'd1 << k) - 64'd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  // Clamp to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* sv/pressure_temperature_compensation.sv */
// Second-order temperature compensation of raw barometric sensor readings.
// Eight-stage streaming pipeline; uses ptc_pkg for constants and helpers.

// One item (raw pressure and raw temperature) enters per clock unless the
// output stalls, and its compensated result appears on out_tdata in order;
// the sustained rate is one item per cycle without stalls, since every one of the
// eight register stages advances whenever the stage after it can take its item
// (the wide pressure multiply is split into two 24x20 partial products that
// are summed one stage later). Each stage holds its item when the one after it
// is full and stalled, so bubbles close up and nothing is dropped or repeated.
// The calibration words and model select are written through the cfg_ port
// (always ready) and must only change while the pipeline is empty. Model 1
// gives pressure in 0.01 mbar, model 0 in 0.1 mbar; temperature is in 0.01 C.
// There is no reset-time clearing pass.
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] pressure_value, [63:32] temperature_value
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        two_bar_r;
  logic [15:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_bar_r <= 1'b0;
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENSOR_MODEL:   two_bar_r <= cfg_data[0];
        REG_PRESS_SENS:     c1_r <= cfg_data;
        REG_PRESS_OFFSET:   c2_r <= cfg_data;
        REG_SENS_TEMP_COEF: c3_r <= cfg_data;
        REG_OFF_TEMP_COEF:  c4_r <= cfg_data;
        REG_REF_TEMP:       c5_r <= cfg_data;
        REG_TEMP_COEF:      c6_r <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids and per-stage ready chain
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  assign rdy[NSTG-1] = !v_r[NSTG-1] || out_tready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dT = D2 - C5*256
  // ---------------------------------------------------------------------------
  logic        [23:0] d1_s1_r;
  logic signed [24:0] dt_s1_r, dt_s1_nxt;

  assign dt_s1_nxt = $signed({1'b0, in_tdata[47:24]}) - $signed({1'b0, c5_r, 8'h00});

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d1_s1_r <= in_tdata[23:0];
      dt_s1_r <= dt_s1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products of dT with C6, C3, C4 and with itself
  // ---------------------------------------------------------------------------
  logic        [23:0] d1_s2_r;
  logic signed [41:0] tprod_s2_r, c3dt_s2_r, c4dt_s2_r;
  logic signed [41:0] tprod_s2_nxt, c3dt_s2_nxt, c4dt_s2_nxt;
  logic signed [49:0] dtsq_full;
  logic        [47:0] dtsq_s2_r;

  assign tprod_s2_nxt = dt_s1_r * $signed({1'b0, c6_r});
  assign c3dt_s2_nxt  = dt_s1_r * $signed({1'b0, c3_r});
  assign c4dt_s2_nxt  = dt_s1_r * $signed({1'b0, c4_r});
  assign dtsq_full    = dt_s1_r * dt_s1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      d1_s2_r    <= d1_s1_r;
      tprod_s2_r <= tprod_s2_nxt;
      c3dt_s2_r  <= c3dt_s2_nxt;
      c4dt_s2_r  <= c4dt_s2_nxt;
      dtsq_s2_r  <= dtsq_full[47:0];  // nonnegative, below 2^48
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: TEMP - 2000, first-order SENS and OFF
  // ---------------------------------------------------------------------------
  logic        [23:0] d1_s3_r;
  logic        [47:0] dtsq_s3_r;
  logic signed [17:0] dtemp_s3_r;
  logic signed [39:0] sens_s3_r, off_s3_r;
  logic signed [63:0] tq_w, sq_w, oq_w;
  logic signed [39:0] sens_base_nxt, off_base_nxt;

  always_comb begin
    tq_w = trunc_shr(64'(tprod_s2_r), SH_TEMP);
    sq_w = trunc_shr(64'(c3dt_s2_r), two_bar_r ? SH_SENS_2BAR : SH_SENS_30B);
    oq_w = trunc_shr(64'(c4dt_s2_r), two_bar_r ? SH_OFF_2BAR : SH_OFF_30B);
    if (two_bar_r) begin
      sens_base_nxt = $signed({8'h00, c1_r, 16'h0000}) + sq_w[39:0];
      off_base_nxt  = $signed({7'h00, c2_r, 17'h00000}) + oq_w[39:0];
    end else begin
      sens_base_nxt = $signed({9'h000, c1_r, 15'h0000}) + sq_w[39:0];
      off_base_nxt  = $signed({8'h00, c2_r, 16'h0000}) + oq_w[39:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      d1_s3_r    <= d1_s2_r;
      dtsq_s3_r  <= dtsq_s2_r;
      dtemp_s3_r <= tq_w[17:0];
      sens_s3_r  <= sens_base_nxt;
      off_s3_r   <= off_base_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: range flags, squares of the temperature deltas, final TEMP
  // ---------------------------------------------------------------------------
  logic        [23:0] d1_s4_r;
  logic signed [39:0] sens_s4_r, off_s4_r;
  logic               low_s4_r, vlow_s4_r;
  logic        [35:0] dq2_s4_r, e2_s4_r;
  logic signed [19:0] temp_s4_r;
  logic               low_w, vlow_w;
  logic signed [35:0] dq2_full;
  logic signed [18:0] e_w;
  logic signed [37:0] e2_full;
  logic        [51:0] ti11_w, ti3_w;
  logic        [16:0] ti_w;
  logic signed [19:0] temp_nxt;

  always_comb begin
    low_w    = dtemp_s3_r[17];                          // TEMP < 20.00 C
    vlow_w   = $signed(19'(dtemp_s3_r)) < -VLOW_OFFSET; // TEMP < -15.00 C
    dq2_full = dtemp_s3_r * dtemp_s3_r;
    e_w      = 19'(dtemp_s3_r) + VLOW_OFFSET;
    e2_full  = e_w * e_w;
    ti11_w   = 52'(dtsq_s3_r) * 52'd11;
    ti3_w    = 52'(dtsq_s3_r) * 52'd3;
    if (two_bar_r) begin
      ti_w = low_w ? 17'(ti11_w >> 35) : '0;
    end else begin
      ti_w = low_w ? 17'(ti3_w >> 33) : 17'(dtsq_s3_r >> 36);
    end
    temp_nxt = TEMP_BASE + 20'(dtemp_s3_r) - $signed({3'b000, ti_w});
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      d1_s4_r   <= d1_s3_r;
      sens_s4_r <= sens_s3_r;
      off_s4_r  <= off_s3_r;
      low_s4_r  <= low_w;
      vlow_s4_r <= vlow_w;
      dq2_s4_r  <= dq2_full[35:0];
      e2_s4_r   <= e2_full[35:0];
      temp_s4_r <= temp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: second-order OFF and SENS corrections
  // ---------------------------------------------------------------------------
  logic        [23:0] d1_s5_r;
  logic signed [39:0] sens_s5_r, off_s5_r;
  logic signed [19:0] temp_s5_r;
  logic        [39:0] offi_w, sensi_w, dq_w, ee_w;

  always_comb begin
    dq_w = 40'(dq2_s4_r);
    ee_w = 40'(e2_s4_r);
    if (two_bar_r) begin
      offi_w  = low_s4_r ? (dq_w * 40'd31) >> 3 : '0;
      sensi_w = low_s4_r ? (dq_w * 40'd63) >> 5 : '0;
    end else if (low_s4_r) begin
      offi_w  = (dq_w * 40'd3) >> 1;
      sensi_w = (dq_w * 40'd5) >> 3;
      if (vlow_s4_r) begin
        offi_w  = offi_w + ee_w * 40'd7;
        sensi_w = sensi_w + (ee_w << 2);
      end
    end else begin
      offi_w  = dq_w >> 4;
      sensi_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      d1_s5_r   <= d1_s4_r;
      sens_s5_r <= sens_s4_r - $signed(sensi_w);
      off_s5_r  <= off_s4_r - $signed(offi_w);
      temp_s5_r <= temp_s4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: D1*SENS as two partial products (low half unsigned)
  // ---------------------------------------------------------------------------
  logic        [43:0] plo_s6_r;
  logic signed [44:0] phi_s6_r;
  logic signed [39:0] off_s6_r;
  logic signed [19:0] temp_s6_r;
  logic signed [44:0] phi_nxt;

  assign phi_nxt = $signed({1'b0, d1_s5_r}) * $signed(sens_s5_r[39:20]);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      plo_s6_r  <= 44'(d1_s5_r) * 44'(sens_s5_r[19:0]);
      phi_s6_r  <= phi_nxt;
      off_s6_r  <= off_s5_r;
      temp_s6_r <= temp_s5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: recombine the product and divide by 2^21
  // ---------------------------------------------------------------------------
  logic signed [42:0] pd_s7_r;
  logic signed [39:0] off_s7_r;
  logic signed [19:0] temp_s7_r;
  logic signed [63:0] prod_w, pd_w;

  always_comb begin
    prod_w = (64'(phi_s6_r) <<< 20) + $signed({20'h00000, plo_s6_r});
    pd_w   = trunc_shr(prod_w, SH_PROD);
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      pd_s7_r   <= pd_w[42:0];
      off_s7_r  <= off_s6_r;
      temp_s7_r <= temp_s6_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: subtract OFF, final scaling, saturation; output register
  // ---------------------------------------------------------------------------
  logic        [63:0] out_tdata_r;
  logic signed [43:0] x_w;
  logic signed [63:0] p_w;

  always_comb begin
    x_w = 44'(pd_s7_r) - 44'(off_s7_r);
    p_w = trunc_shr(64'(x_w), two_bar_r ? SH_P_2BAR : SH_P_30B);
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      out_tdata_r <= {sat32(64'(temp_s7_r)), sat32(p_w)};
    end
  end

  assign out_tdata = out_tdata_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An empty output stage means nothing can block the input side.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  // An item leaving the last inner stage lands in the output register.
  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-2] && rdy[NSTG-1]) |=> out_tvalid)
    else $error("item lost between last stage and output");

  // A stalled output with a full stage behind it keeps both items.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && v_r[NSTG-2]) |=> (out_tvalid && v_r[NSTG-2]))
    else $error("item dropped during output stall");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for pressure_temperature_compensation: streams raw sensor pairs,
// predicts each compensated result and compares them in order. Depends on ptc_pkg.
module tb;
  import ptc_pkg::*;

  // Index that maps to no register; writes to it must be ignored
  localparam logic [2:0] REG_NONE = 3'd7;

  localparam longint TEMP_20C    = 64'sd2000;
  localparam longint TEMP_M15C   = -64'sd1500;
  localparam longint TWO_POW_21  = 64'sd2097152;
  localparam longint TWO_POW_23  = 64'sd8388608;
  localparam longint TWO_POW_33  = 64'sd8589934592;
  localparam longint TWO_POW_35  = 64'sd34359738368;
  localparam longint TWO_POW_37  = 64'sd137438953472;
  localparam int     LONG_HOLD   = 64;
  localparam int     RAND_PHASES = 10;
  localparam int     PHASE_ITEMS = 103;

  typedef struct packed {
    logic [23:0] temperature;
    logic [23:0] pressure;
  } raw_pair_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;    // [23:0] raw_pressure, [47:24] raw_temperature
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // [31:0] pressure_value, [63:32] temperature_value
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Calibration words as the block should hold them
  logic [15:0] cal_word [0:6] = '{default: 16'd0};

  raw_pair_t pending_q [$];
  reading_t  expected_q [$];
  int        in_gap = 0;
  logic      in_taken = 1'b0;
  logic      in_burst = 1'b0;
  logic      out_burst = 1'b0;
  logic      long_hold_req = 1'b0;
  int        rcv_wait = 0;
  int        mismatch_count = 0;

  pressure_temperature_compensation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Compensated pressure and temperature for one raw pair, current calibration
  function automatic reading_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, dtemp, sens, off, ti, offi, sensi, p, e;
    reading_t r;
    d1 = raw_p;
    d2 = raw_t;
    c1 = cal_word[REG_PRESS_SENS];
    c2 = cal_word[REG_PRESS_OFFSET];
    c3 = cal_word[REG_SENS_TEMP_COEF];
    c4 = cal_word[REG_OFF_TEMP_COEF];
    c5 = cal_word[REG_REF_TEMP];
    c6 = cal_word[REG_TEMP_COEF];
    ti = 0;
    offi = 0;
    sensi = 0;
    dt = d2 - c5 * 256;
    temp = TEMP_20C + dt * c6 / TWO_POW_23;
    dtemp = temp - TEMP_20C;
    if (cal_word[REG_SENSOR_MODEL][0]) begin
      // 2 bar scaling; correction only below 20 C
      sens = c1 * 65536 + c3 * dt / 128;
      off = c2 * 131072 + c4 * dt / 64;
      if (temp < TEMP_20C) begin
        ti = 11 * dt * dt / TWO_POW_35;
        offi = 31 * dtemp * dtemp / 8;
        sensi = 63 * dtemp * dtemp / 32;
      end
    end else begin
      // 30 bar scaling; extra term below -15 C, small term at or above 20 C
      sens = c1 * 32768 + c3 * dt / 256;
      off = c2 * 65536 + c4 * dt / 128;
      if (temp < TEMP_20C) begin
        ti = 3 * dt * dt / TWO_POW_33;
        offi = 3 * dtemp * dtemp / 2;
        sensi = 5 * dtemp * dtemp / 8;
        if (temp < TEMP_M15C) begin
          e = temp - TEMP_M15C;
          offi = offi + 7 * e * e;
          sensi = sensi + 4 * e * e;
        end
      end else begin
        ti = 2 * dt * dt / TWO_POW_37;
        offi = dtemp * dtemp / 16;
      end
    end
    off = off - offi;
    sens = sens - sensi;
    if (cal_word[REG_SENSOR_MODEL][0]) p = (d1 * sens / TWO_POW_21 - off) / 32768;
    else p = (d1 * sens / TWO_POW_21 - off) / 8192;
    r.pressure = clamp32(p);
    r.temperature = clamp32(temp - ti);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [15:0] pick_coef();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Raw temperature landing near 20 C or -15 C for the current calibration
  function automatic logic [23:0] raw_temp_near_edge();
    longint base, dt, d2, step;
    int pick, jitter;
    pick = $urandom_range(0, 3);
    jitter = $urandom_range(0, 600);
    base = longint'(cal_word[REG_REF_TEMP]) * 256;
    dt = 0;
    if (cal_word[REG_TEMP_COEF] != 16'd0) begin
      step = TWO_POW_23 / longint'(cal_word[REG_TEMP_COEF]);
      dt = (pick[1] ? -3500 : 0) * step - (pick[0] ? step : 0);
    end
    d2 = base + dt + jitter - 300;
    if (d2 < 0) d2 = 0;
    if (d2 > 64'sd16777215) d2 = 64'sd16777215;
    return d2[23:0];
  endfunction

  function automatic raw_pair_t random_pair();
    raw_pair_t v;
    int rp, rt;
    rp = $urandom_range(0, 9);
    rt = $urandom_range(0, 9);
    v.pressure = (rp == 0) ? 24'h000000 : (rp == 1) ? 24'hFFFFFF : 24'($urandom);
    if (rt == 0) v.temperature = 24'h000000;
    else if (rt == 1) v.temperature = 24'hFFFFFF;
    else if (rt < 5) v.temperature = raw_temp_near_edge();
    else v.temperature = 24'($urandom);
    return v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SENSOR_MODEL) cal_word[idx] = {15'd0, val[0]};
    else if (idx <= REG_TEMP_COEF) cal_word[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_cal(input logic [15:0] model, c1, c2, c3, c4, c5, c6);
    write_reg(REG_SENSOR_MODEL, model);
    write_reg(REG_PRESS_SENS, c1);
    write_reg(REG_PRESS_OFFSET, c2);
    write_reg(REG_SENS_TEMP_COEF, c3);
    write_reg(REG_OFF_TEMP_COEF, c4);
    write_reg(REG_REF_TEMP, c5);
    write_reg(REG_TEMP_COEF, c6);
  endtask

  task automatic push_pair(input logic [23:0] raw_p, input logic [23:0] raw_t);
    pending_q.push_back('{temperature: raw_t, pressure: raw_p});
  endtask

  // Zero and full-scale readings plus one typical pair
  task automatic push_corners();
    push_pair(24'h000000, 24'h000000);
    push_pair(24'hFFFFFF, 24'hFFFFFF);
    push_pair(24'h000000, 24'hFFFFFF);
    push_pair(24'hFFFFFF, 24'h000000);
    push_pair(24'd4958179, 24'd6815414);
  endtask

  // Sender pauses until every result is back, then the pipeline settles
  task automatic wait_pipeline_empty();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (NSTG + 2) @(posedge clk);
  endtask

  // Input driver: offer the next pending item, with random gaps
  always @(negedge clk) begin : drive_in
    raw_pair_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold until accepted
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_q.size() > 0) begin
      nxt = pending_q.pop_front();
      in_tdata <= nxt;
      in_tvalid <= 1'b1;
      in_gap <= in_burst ? 0 : pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Accepted input item: record its expected reading
  always @(posedge clk) begin : track_in
    if (rst_n && in_tvalid && in_tready) begin
      expected_q.push_back(compensate(in_tdata[23:0], in_tdata[47:24]));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Result receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin : drive_out
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rcv_wait = LONG_HOLD;
      end
      if (rcv_wait > 0) begin
        out_tready <= 1'b0;
        rcv_wait = rcv_wait - 1;
      end else if (out_burst || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rcv_wait = pick_gap();
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check_out
    reading_t want;
    logic signed [31:0] got_p, got_t;
    if (rst_n && out_tvalid && out_tready) begin
      got_p = out_tdata[31:0];
      got_t = out_tdata[63:32];
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result pressure=%0d temperature=%0d", $time, got_p, got_t);
      end else begin
        want = expected_q.pop_front();
        if (got_p !== want.pressure || got_t !== want.temperature) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch pressure exp=%0d got=%0d, temperature exp=%0d got=%0d",
                     $time, want.pressure, got_p, want.temperature, got_t);
        end
      end
    end
  end

  initial begin : stimulus
    int ph;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Calibration left at reset values
    push_pair(24'h000000, 24'h000000);
    push_pair(24'hFFFFFF, 24'hFFFFFF);
    wait_pipeline_empty();

    // Typical 2 bar calibration
    load_cal(16'd1, 16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
    push_corners();
    wait_pipeline_empty();

    // All words at full scale, 30 bar; then a stray write to an unmapped index
    load_cal(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_NONE, 16'h5A5A);
    push_corners();
    wait_pipeline_empty();

    // All words at full scale, 2 bar
    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_corners();
    wait_pipeline_empty();

    // Typical 30 bar calibration
    load_cal(16'hFFFE, 16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165);
    push_corners();
    wait_pipeline_empty();

    // Random phases, some keeping the previous calibration
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      in_burst = (ph == 2) || ($urandom_range(0, 3) == 0);
      out_burst = (ph != 2) && ($urandom_range(0, 3) == 0);
      if (ph == 0 || $urandom_range(0, 3) != 0)
        load_cal(16'($urandom), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                 pick_coef(), pick_coef());
      // receiver holds off while the sender streams, so the input backs up
      if (ph == 2) long_hold_req = 1'b1;
      repeat (PHASE_ITEMS) pending_q.push_back(random_pair());
      wait_pipeline_empty();
    end

    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/ptc_pkg.sv
sv/pressure_temperature_compensation.sv
test/tb.sv
